>>> rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// Palette pattern pixel generator package
// Shared widths, codes, state type and the configuration bundle.
// ----------------------------------------------------------------------------
package ppg_pkg;

   // Field widths of the request and response beats.
   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int CNT_W   = 11;
   localparam int CHAN_W  = 8;
   localparam int RGB_W   = 3 * CHAN_W;

   // Configuration register widths.
   localparam int PHASE_W = 16;
   localparam int SEG_W   = 5;
   localparam int GAP_W   = 8;
   localparam int BRT_W   = 9;
   localparam int NCOL_W  = 3;
   localparam int PAL_W   = 2 * RGB_W;

   // Configuration port geometry: eight registers, 64-bit data, 8-byte stride.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   // Divider geometry: index times segments, then sixteen fraction bits.
   localparam int NUM_W     = IDX_W + SEG_W;
   localparam int FRAC_W    = PHASE_W;
   localparam int DIV_STEPS = NUM_W + FRAC_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Operation codes carried on the request channel.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
   localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SEGMENTS     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAP_RATIO    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BLEND        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_COUNT  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_PALETTE_LOW  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_PALETTE_HIGH = 3'd7;

   // Configuration bundle handed from the register file to the datapath.
   typedef struct packed {
      logic [PHASE_W-1:0] phase_step;
      logic [SEG_W-1:0]   segments;
      logic [GAP_W-1:0]   gap_ratio;
      logic [BRT_W-1:0]   brightness;
      logic               blend_gradient;
      logic [NCOL_W-1:0]  color_count;
      logic [PAL_W-1:0]   palette_low;
      logic [PAL_W-1:0]   palette_high;
   } cfg_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_COLOUR,
      ST_DONE
   } state_type;

endpackage

>>> rtl/ppg_csr.sv
// ----------------------------------------------------------------------------
// Palette pattern configuration registers
// APB-style register file holding the pattern and palette settings.
// ----------------------------------------------------------------------------
module ppg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ppg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ppg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ppg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output ppg_pkg::cfg_type                cfg
);
   import ppg_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   // Registers sit on an 8-byte stride; the low address bits are ignored.
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Write decode: one register per completed write beat.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PHASE_STEP:   cfg_in.phase_step     = pwdata[PHASE_W-1:0];
            REG_SEGMENTS:     cfg_in.segments       = pwdata[SEG_W-1:0];
            REG_GAP_RATIO:    cfg_in.gap_ratio      = pwdata[GAP_W-1:0];
            REG_BRIGHTNESS:   cfg_in.brightness     = pwdata[BRT_W-1:0];
            REG_BLEND:        cfg_in.blend_gradient = pwdata[0];
            REG_COLOR_COUNT:  cfg_in.color_count    = pwdata[NCOL_W-1:0];
            REG_PALETTE_LOW:  cfg_in.palette_low    = pwdata[PAL_W-1:0];
            REG_PALETTE_HIGH: cfg_in.palette_high   = pwdata[PAL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step     <= '0;
         cfg_ff.segments       <= SEG_W'(1);
         cfg_ff.gap_ratio      <= '0;
         cfg_ff.brightness     <= BRT_W'(256);
         cfg_ff.blend_gradient <= 1'b0;
         cfg_ff.color_count    <= '0;
         cfg_ff.palette_low    <= '0;
         cfg_ff.palette_high   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_idx)
         REG_PHASE_STEP:   prdata = CSR_DATA_W'(cfg_ff.phase_step);
         REG_SEGMENTS:     prdata = CSR_DATA_W'(cfg_ff.segments);
         REG_GAP_RATIO:    prdata = CSR_DATA_W'(cfg_ff.gap_ratio);
         REG_BRIGHTNESS:   prdata = CSR_DATA_W'(cfg_ff.brightness);
         REG_BLEND:        prdata = CSR_DATA_W'(cfg_ff.blend_gradient);
         REG_COLOR_COUNT:  prdata = CSR_DATA_W'(cfg_ff.color_count);
         REG_PALETTE_LOW:  prdata = CSR_DATA_W'(cfg_ff.palette_low);
         REG_PALETTE_HIGH: prdata = CSR_DATA_W'(cfg_ff.palette_high);
         default:          prdata = '0;
      endcase
   end

endmodule

>>> rtl/ppg_div.sv
// ----------------------------------------------------------------------------
// Palette pattern bit-serial divider
// Restoring long division of (index*segments << 16) by the pixel count,
// one quotient bit per cycle; keeps the sixteen fraction bits of the result.
// ----------------------------------------------------------------------------
module ppg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppg_pkg::NUM_W-1:0]     dividend,
   input  logic [ppg_pkg::CNT_W-1:0]     divisor,
   output logic                          done,
   output logic [ppg_pkg::FRAC_W-1:0]    quotient
);
   import ppg_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    den_ff, den_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [FRAC_W-1:0]   quot_ff, quot_in;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;
   logic                fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   // After the dividend is used up, zeros are shifted in for the fraction.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quot_in = {quot_ff[FRAC_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> rtl/ppg_colour.sv
// ----------------------------------------------------------------------------
// Palette pattern colour unit
// Picks the palette slot for a pattern position, applies the gap, blends
// towards the next entry and scales by brightness, one channel byte a cycle.
// ----------------------------------------------------------------------------
module ppg_colour (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ppg_pkg::PHASE_W-1:0]     pos,
   input  logic [ppg_pkg::NCOL_W-1:0]      n_used,
   input  ppg_pkg::cfg_type                cfg,
   output logic                            done,
   output logic [ppg_pkg::CHAN_W-1:0]      red,
   output logic [ppg_pkg::CHAN_W-1:0]      green,
   output logic [ppg_pkg::CHAN_W-1:0]      blue
);
   import ppg_pkg::*;

   localparam int          SEQ_W     = 3;
   localparam logic [SEQ_W-1:0] SEQ_IDLE  = 3'd0;
   localparam logic [SEQ_W-1:0] SEQ_FIRST = 3'd1;
   localparam logic [SEQ_W-1:0] SEQ_SCALE = 3'd2;
   localparam logic [SEQ_W-1:0] SEQ_LAST  = 3'd4;
   localparam int          SLOT_W    = 2;
   localparam int          SPOS_W    = PHASE_W + SLOT_W;
   localparam int          PROD_W    = CHAN_W + 1 + PHASE_W + 1;
   localparam int          SCL_W     = CHAN_W + BRT_W;

   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic                done_ff, done_in;
   logic [RGB_W-1:0]    c1_ff, c2_ff;
   logic [PHASE_W-1:0]  slot_frac_ff;
   logic                solid_ff, gap_ff;
   logic [CHAN_W-1:0]   blend_ff;
   logic [RGB_W-1:0]    rgb_ff;

   logic [SPOS_W-1:0]   spos;
   logic [SLOT_W-1:0]   slot;
   logic [SLOT_W-1:0]   slot_next;
   logic [PHASE_W-1:0]  slot_frac;
   logic [PHASE_W:0]    gap_limit;
   logic                gap_hit;

   logic signed [CHAN_W:0]    chan_diff;
   logic signed [PROD_W-1:0]  chan_prod;
   logic signed [PROD_W-1:0]  chan_sum;
   logic [CHAN_W-1:0]         blend;
   logic [SCL_W-1:0]          scaled;
   logic [CHAN_W-1:0]         scaled_sat;

   // Palette entry lookup: entries 0 and 1 in the low word, 2 and 3 in the high.
   function automatic logic [RGB_W-1:0] pal_entry(input logic [PAL_W-1:0] lo_word,
                                                  input logic [PAL_W-1:0] hi_word,
                                                  input logic [SLOT_W-1:0] e);
      logic [PAL_W-1:0] word;
      word = e[1] ? hi_word : lo_word;
      return e[0] ? word[PAL_W-1:RGB_W] : word[RGB_W-1:0];
   endfunction

   // Slot and position within the slot; slot stays below n_used by range.
   assign spos      = SPOS_W'(pos) * SPOS_W'(n_used);
   assign slot      = spos[SPOS_W-1:PHASE_W];
   assign slot_frac = spos[PHASE_W-1:0];
   assign slot_next = ({1'b0, slot} + NCOL_W'(1) == n_used) ? '0 : slot + SLOT_W'(1);

   // Trailing gap of each slot is black.
   assign gap_limit = (PHASE_W+1)'(1 << PHASE_W) - {1'b0, cfg.gap_ratio, 8'h00};
   assign gap_hit   = (cfg.gap_ratio != '0) && ({1'b0, slot_frac} > gap_limit);

   // Linear blend written as a + (b - a) * w, then a Q0.16 shift.
   assign chan_diff = $signed({1'b0, c2_ff[RGB_W-1 -: CHAN_W]})
                    - $signed({1'b0, c1_ff[RGB_W-1 -: CHAN_W]});
   assign chan_prod = PROD_W'(chan_diff) * $signed({{(PROD_W-PHASE_W){1'b0}}, slot_frac_ff});
   assign chan_sum  = $signed({{(PROD_W-CHAN_W-PHASE_W){1'b0}},
                               c1_ff[RGB_W-1 -: CHAN_W], {PHASE_W{1'b0}}}) + chan_prod;
   assign blend     = solid_ff ? c1_ff[RGB_W-1 -: CHAN_W]
                               : chan_sum[PHASE_W +: CHAN_W];

   // Brightness scale; a product of 256 or more after the shift clips to 255.
   assign scaled     = SCL_W'(blend_ff) * SCL_W'(cfg.brightness);
   assign scaled_sat = scaled[SCL_W-1] ? '1 : scaled[CHAN_W +: CHAN_W];

   // Sequencer: a setup step, then blend and scale overlap by one byte.
   always_comb begin
      seq_in  = seq_ff;
      done_in = 1'b0;
      if (start) begin
         seq_in = SEQ_FIRST;
      end else if (seq_ff == SEQ_LAST) begin
         seq_in  = SEQ_IDLE;
         done_in = 1'b1;
      end else if (seq_ff != SEQ_IDLE) begin
         seq_in = seq_ff + SEQ_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= SEQ_IDLE;
         done_ff <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         done_ff <= done_in;
      end
   end

   // Datapath: entries shift out red first, scaled bytes shift in behind.
   always_ff @(posedge clock) begin
      if (start) begin
         c1_ff        <= pal_entry(cfg.palette_low, cfg.palette_high, slot);
         c2_ff        <= pal_entry(cfg.palette_low, cfg.palette_high, slot_next);
         slot_frac_ff <= slot_frac;
         solid_ff     <= !cfg.blend_gradient || (n_used == NCOL_W'(1));
         gap_ff       <= gap_hit;
      end else if (seq_ff != SEQ_IDLE) begin
         c1_ff    <= {c1_ff[RGB_W-CHAN_W-1:0], {CHAN_W{1'b0}}};
         c2_ff    <= {c2_ff[RGB_W-CHAN_W-1:0], {CHAN_W{1'b0}}};
         blend_ff <= blend;
         if (seq_ff >= SEQ_SCALE) begin
            rgb_ff <= {rgb_ff[RGB_W-CHAN_W-1:0], gap_ff ? {CHAN_W{1'b0}} : scaled_sat};
         end
      end
   end

   assign done  = done_ff;
   assign red   = rgb_ff[RGB_W-1 -: CHAN_W];
   assign green = rgb_ff[CHAN_W +: CHAN_W];
   assign blue  = rgb_ff[CHAN_W-1:0];

endmodule

>>> rtl/palette_pattern_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// Palette pattern pixel generator
// Start, frame and pixel beats in; one scaled RGB colour out per pixel beat.
// ----------------------------------------------------------------------------
// A start or frame beat is taken while the sequencer is idle and updates the
// animation phase (and, for a frame, the active pixel count) at once. A pixel
// beat holds the request channel while it is in work: it loads the bit-serial
// divider, which produces the quotient bits of the pattern position
// index*segments/count as a sixteen-bit fraction; then it loads the colour
// unit, which blends and scales one channel byte per cycle, hands completion
// to the sequencer and loads the output register. A pixel that is black
// because the palette is empty or the count is zero skips the divider and the
// colour unit and goes through the done state into the output register. The
// request channel stalls while a pixel is in work, and longer while a held
// colour still blocks the output register; a finished colour sits in the
// output register, so the next beat is taken while it waits to be collected.
module palette_pattern_pixel_generator_top #(
   parameter int MAX_PIXELS   = 1024,
   parameter int PALETTE_SIZE = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppg_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ppg_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ppg_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ppg_pkg::OP_W-1:0]        req_op,
   input  logic [ppg_pkg::IDX_W-1:0]       req_pixel_index,
   input  logic [ppg_pkg::CNT_W-1:0]       req_pixel_count,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ppg_pkg::IDX_W-1:0]       rsp_pixel_out_index,
   output logic [ppg_pkg::CHAN_W-1:0]      rsp_red,
   output logic [ppg_pkg::CHAN_W-1:0]      rsp_green,
   output logic [ppg_pkg::CHAN_W-1:0]      rsp_blue
);
   import ppg_pkg::*;

   cfg_type              cfg;
   state_type            state_ff, state_in;

   logic [PHASE_W-1:0]   anim_phase_ff;
   logic [CNT_W-1:0]     active_pixels_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 pix_black_ff;

   logic                 rsp_valid_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [CHAN_W-1:0]    rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic                 req_accept;
   logic                 pixel_accept;
   logic                 div_start, div_done, col_start, col_done, rsp_load;
   logic                 out_free;
   logic                 black_now;
   logic [NCOL_W-1:0]    n_used;
   logic [NUM_W-1:0]     num;
   logic [FRAC_W-1:0]    div_quot;
   logic [PHASE_W-1:0]   pos;
   logic [CHAN_W-1:0]    col_red, col_green, col_blue;

   // Configuration registers.
   ppg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Handshake and per-beat decode.
   assign req_accept   = req_valid && !req_stall;
   assign pixel_accept = req_accept && (req_op == OP_PIXEL);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Palette entries in use, capped at the palette size.
   assign n_used    = (32'(cfg.color_count) > PALETTE_SIZE) ? NCOL_W'(PALETTE_SIZE)
                                                             : cfg.color_count;
   assign black_now = (n_used == '0) || (active_pixels_ff == '0);
   assign num       = NUM_W'(req_pixel_index) * NUM_W'(cfg.segments);
   assign pos       = div_quot + anim_phase_ff;

   // Bit-serial position divider.
   ppg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num),
      .divisor  (active_pixels_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Slot, gap, blend and brightness unit.
   ppg_colour u_colour (
      .clock  (clock),
      .reset  (reset),
      .start  (col_start),
      .pos    (pos),
      .n_used (n_used),
      .cfg    (cfg),
      .done   (col_done),
      .red    (col_red),
      .green  (col_green),
      .blue   (col_blue)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pixel_accept) begin
               state_in = black_now ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_COLOUR;
            end
         end
         ST_COLOUR: begin
            if (col_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      col_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid && (req_op == OP_PIXEL) && !black_now;
         end
         ST_DIVIDE: col_start = div_done;
         ST_COLOUR: req_stall = 1'b1;
         ST_DONE:   rsp_load  = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // Control state: sequencer, animation phase, active pixel count and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         anim_phase_ff    <= '0;
         active_pixels_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (req_accept && (req_op == OP_START)) begin
            anim_phase_ff <= '0;
         end else if (req_accept && (req_op == OP_FRAME)) begin
            anim_phase_ff <= anim_phase_ff + cfg.phase_step;
            active_pixels_ff <= (32'(req_pixel_count) > MAX_PIXELS) ? CNT_W'(MAX_PIXELS)
                                                                    : req_pixel_count;
         end
      end
   end

   // Pixel context held while the beat is in work.
   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         idx_ff       <= req_pixel_index;
         pix_black_ff <= black_now;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= idx_ff;
         rsp_red_ff   <= pix_black_ff ? '0 : col_red;
         rsp_green_ff <= pix_black_ff ? '0 : col_green;
         rsp_blue_ff  <= pix_black_ff ? '0 : col_blue;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_out_index = rsp_index_ff;
   assign rsp_red             = rsp_red_ff;
   assign rsp_green           = rsp_green_ff;
   assign rsp_blue            = rsp_blue_ff;

   // The divider reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   // The colour unit reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      col_done |-> (state_ff == ST_COLOUR))
      else $error("colour unit finished outside the colour state");

   // A new result never overwrites one that is still held by the receiver.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   // A frame beat advances the phase by exactly one step.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_FRAME)) |=>
         (anim_phase_ff == $past(anim_phase_ff + cfg.phase_step)))
      else $error("phase did not advance by one step");

   // The latched pixel count never exceeds the supported maximum.
   assert property (@(posedge clock) disable iff (reset)
      32'(active_pixels_ff) <= MAX_PIXELS)
      else $error("active pixel count above maximum");

endmodule
